@@ hdl/edf_pkg.sv @@
// Shared constants, codes and types for the earliest-deadline task selector.
package edf_pkg;

   localparam int TASK_SLOTS_DEF = 8;
   localparam int COUNT_BITS_DEF = 16;

   localparam logic [31:0] IDLE_REF = 32'hFFFF_FFFF;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_STATE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   localparam logic [1:0] RUN_EMPTY = 2'd0;
   localparam logic [1:0] RUN_READY = 2'd1;
   localparam logic [1:0] RUN_WAIT  = 2'd2;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DRAIN,
      SEQ_COMMIT
   } seq_state_type;

   typedef struct packed {
      logic clear;
      logic valid;
      logic ready;
   } pick_ctrl_type;

endpackage

@@ hdl/edf_slot_mem.sv @@
// Slot table memory: one write port, one registered read port.
module edf_slot_mem #(
   parameter int DEPTH = edf_pkg::TASK_SLOTS_DEF,
   parameter int WIDTH = 4 * edf_pkg::COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/edf_pick_unit.sv @@
// Shared reload, compare and count-down unit; holds the best candidate of a scan.
module edf_pick_unit #(
   parameter int COUNT_BITS = edf_pkg::COUNT_BITS_DEF,
   parameter int SLOT_BITS  = $clog2(edf_pkg::TASK_SLOTS_DEF)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  edf_pkg::pick_ctrl_type    ctrl,
   input  logic [SLOT_BITS-1:0]      idx,
   input  logic [4*COUNT_BITS-1:0]   rd_word,
   output logic [4*COUNT_BITS-1:0]   wb_word,
   output logic [4*COUNT_BITS-1:0]   best_word,
   output logic [SLOT_BITS-1:0]      best_idx,
   output logic                      found
);

   logic [COUNT_BITS-1:0] per, bud, pl, bl, pl0, bl0, pl1;
   logic [31:0]           left_ext, per_ext;
   logic                  win;

   logic [31:0]             best_left_ff, best_left_in;
   logic [31:0]             best_per_ff, best_per_in;
   logic [4*COUNT_BITS-1:0] best_word_ff, best_word_in;
   logic [SLOT_BITS-1:0]    best_idx_ff, best_idx_in;
   logic                    found_ff, found_in;

   assign bl  = rd_word[COUNT_BITS-1:0];
   assign pl  = rd_word[2*COUNT_BITS-1:COUNT_BITS];
   assign bud = rd_word[3*COUNT_BITS-1:2*COUNT_BITS];
   assign per = rd_word[4*COUNT_BITS-1:3*COUNT_BITS];

   always_comb begin
      pl0      = (pl == '0) ? per : pl;
      bl0      = (pl == '0) ? bud : bl;
      pl1      = (ctrl.ready && pl0 != '0) ? pl0 - COUNT_BITS'(1) : pl0;
      wb_word  = {per, bud, pl1, bl0};
      left_ext = 32'(pl0);
      per_ext  = 32'(per);
      win      = ctrl.valid && ctrl.ready && (bl0 != '0) &&
                 ((left_ext < best_left_ff) ||
                  (left_ext == best_left_ff && per_ext < best_per_ff));
   end

   always_comb begin
      best_left_in = best_left_ff;
      best_per_in  = best_per_ff;
      best_word_in = best_word_ff;
      best_idx_in  = best_idx_ff;
      found_in     = found_ff;
      if (ctrl.clear) begin
         best_left_in = edf_pkg::IDLE_REF;
         best_per_in  = edf_pkg::IDLE_REF;
         found_in     = 1'b0;
      end else if (win) begin
         best_left_in = left_ext;
         best_per_in  = per_ext;
         best_word_in = wb_word;
         best_idx_in  = idx;
         found_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_left_ff <= best_left_in;
      best_per_ff  <= best_per_in;
      best_word_ff <= best_word_in;
      best_idx_ff  <= best_idx_in;
   end

   assign best_word = best_word_ff;
   assign best_idx  = best_idx_ff;
   assign found     = found_ff;

endmodule

@@ hdl/edf_task_selector.sv @@
// Top level of the earliest-deadline task selector: sequencer, slot states and result register.
// Usage:
// Input words arrive on req_*: req_tuser carries the kind (load slot, set run state, tick).
// Load and state words give no result.
// A tick gives one result word on rsp_*: rsp_tdata holds the chosen slot and rsp_tuser
// is high when no slot was elected (idle runs; slot then reads zero).
// A tick with at least one ready slot sweeps the slot table one entry per cycle through
// a single memory read port and one shared compare unit, passing through the scan and
// drain states to the commit state, which loads the result register; the next word is
// taken once the sequencer is back in idle. A tick with no ready slot goes straight to
// the commit state.
// req_tready is low while a tick is in progress.
// The result register holds its word until rsp_tready; load and state words are still
// taken meanwhile, but a tick that finishes while the register is full waits for it.
// Synchronous reset empties every slot, selects slot 0 as scan start and drops any
// pending result; no clearing pass is needed.
module edf_task_selector #(
   parameter int TASK_SLOTS = edf_pkg::TASK_SLOTS_DEF,
   parameter int COUNT_BITS = edf_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // slot[2:0], period[18:3], budget[34:19], run_state[36:35]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // chosen_slot[2:0]
   output logic        rsp_tuser    // idle_chosen[0]
);

   localparam int SLOT_BITS = $clog2(TASK_SLOTS);
   localparam int CNT_W     = $clog2(TASK_SLOTS + 1);
   localparam int WORD_W    = 4 * COUNT_BITS;

   logic [1:0]  req_kind;
   logic [2:0]  req_slot;
   logic [15:0] req_period;
   logic [15:0] req_budget;
   logic [1:0]  req_run_state;

   edf_pkg::seq_state_type state_ff, state_in;

   logic [TASK_SLOTS-1:0] ready_bits_ff, ready_bits_in;
   logic [TASK_SLOTS-1:0] wait_bits_ff, wait_bits_in;
   logic [SLOT_BITS-1:0]  last_winner_ff, last_winner_in;
   logic                  was_idle_ff, was_idle_in;
   logic [SLOT_BITS-1:0]  issue_idx_ff, issue_idx_in;
   logic [CNT_W-1:0]      issue_cnt_ff, issue_cnt_in;
   logic                  proc_valid_ff, proc_valid_in;
   logic [SLOT_BITS-1:0]  proc_idx_ff, proc_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_slot_ff, rsp_slot_in;
   logic                  rsp_idle_ff, rsp_idle_in;

   logic                  accept, slot_ok, any_ready, is_tick, rsp_free, commit;
   logic                  proc_busy, last_issue;
   logic [SLOT_BITS-1:0]  slot_idx;

   logic                  wr_en;
   logic [SLOT_BITS-1:0]  wr_addr;
   logic [WORD_W-1:0]     wr_data, rd_data, wb_word, best_word;
   logic [SLOT_BITS-1:0]  best_idx;
   logic                  found;
   edf_pkg::pick_ctrl_type pick_ctrl;

   assign req_kind      = req_tuser;
   assign req_slot      = req_tdata[2:0];
   assign req_period    = req_tdata[18:3];
   assign req_budget    = req_tdata[34:19];
   assign req_run_state = req_tdata[36:35];

   assign req_tready = (state_ff == edf_pkg::SEQ_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_tick    = (req_kind == edf_pkg::KIND_TICK);
   assign slot_ok    = 32'(req_slot) < TASK_SLOTS;
   assign slot_idx   = SLOT_BITS'(req_slot);
   assign any_ready  = |ready_bits_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == edf_pkg::SEQ_COMMIT) && rsp_free;
   assign last_issue = (issue_cnt_ff == CNT_W'(1));
   assign proc_busy  = ready_bits_ff[proc_idx_ff] || wait_bits_ff[proc_idx_ff];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         edf_pkg::SEQ_IDLE: begin
            if (accept && is_tick) begin
               state_in = any_ready ? edf_pkg::SEQ_SCAN : edf_pkg::SEQ_COMMIT;
            end
         end
         edf_pkg::SEQ_SCAN: begin
            if (last_issue) begin
               state_in = edf_pkg::SEQ_DRAIN;
            end
         end
         edf_pkg::SEQ_DRAIN: begin
            state_in = edf_pkg::SEQ_COMMIT;
         end
         edf_pkg::SEQ_COMMIT: begin
            if (rsp_free) begin
               state_in = edf_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = edf_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      issue_idx_in  = issue_idx_ff;
      issue_cnt_in  = issue_cnt_ff;
      proc_valid_in = (state_ff == edf_pkg::SEQ_SCAN);
      proc_idx_in   = issue_idx_ff;
      ready_bits_in = ready_bits_ff;
      wait_bits_in  = wait_bits_ff;
      last_winner_in = last_winner_ff;
      was_idle_in   = was_idle_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_idle_in   = rsp_idle_ff;
      wr_en         = 1'b0;
      wr_addr       = proc_idx_ff;
      wr_data       = wb_word;
      pick_ctrl.clear = accept && is_tick;
      pick_ctrl.valid = proc_valid_ff;
      pick_ctrl.ready = ready_bits_ff[proc_idx_ff];

      unique case (state_ff)
         edf_pkg::SEQ_IDLE: begin
            if (accept && is_tick) begin
               issue_idx_in = was_idle_ff ? '0 : last_winner_ff;
               issue_cnt_in = CNT_W'(TASK_SLOTS);
            end else if (accept && slot_ok && req_kind == edf_pkg::KIND_LOAD) begin
               wr_en   = 1'b1;
               wr_addr = slot_idx;
               wr_data = {COUNT_BITS'(req_period), COUNT_BITS'(req_budget),
                          COUNT_BITS'(0), COUNT_BITS'(0)};
               ready_bits_in[slot_idx] = 1'b1;
               wait_bits_in[slot_idx]  = 1'b0;
            end else if (accept && slot_ok && req_kind == edf_pkg::KIND_STATE) begin
               case (req_run_state)
                  edf_pkg::RUN_EMPTY: begin
                     ready_bits_in[slot_idx] = 1'b0;
                     wait_bits_in[slot_idx]  = 1'b0;
                  end
                  edf_pkg::RUN_READY: begin
                     ready_bits_in[slot_idx] = 1'b1;
                     wait_bits_in[slot_idx]  = 1'b0;
                  end
                  edf_pkg::RUN_WAIT: begin
                     ready_bits_in[slot_idx] = 1'b0;
                     wait_bits_in[slot_idx]  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         edf_pkg::SEQ_SCAN: begin
            issue_cnt_in = issue_cnt_ff - CNT_W'(1);
            issue_idx_in = (issue_idx_ff == SLOT_BITS'(TASK_SLOTS - 1)) ?
                           '0 : issue_idx_ff + SLOT_BITS'(1);
            wr_en = proc_valid_ff && proc_busy;
         end
         edf_pkg::SEQ_DRAIN: begin
            wr_en = proc_valid_ff && proc_busy;
         end
         edf_pkg::SEQ_COMMIT: begin
            if (rsp_free) begin
               wr_en        = found;
               wr_addr      = best_idx;
               wr_data      = {best_word[WORD_W-1:COUNT_BITS],
                               best_word[COUNT_BITS-1:0] - COUNT_BITS'(1)};
               was_idle_in  = !found;
               last_winner_in = found ? best_idx : last_winner_ff;
               rsp_valid_in = 1'b1;
               rsp_slot_in  = found ? 3'(best_idx) : 3'd0;
               rsp_idle_in  = !found;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= edf_pkg::SEQ_IDLE;
         ready_bits_ff  <= '0;
         wait_bits_ff   <= '0;
         last_winner_ff <= '0;
         was_idle_ff    <= 1'b1;
         issue_cnt_ff   <= '0;
         proc_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ready_bits_ff  <= ready_bits_in;
         wait_bits_ff   <= wait_bits_in;
         last_winner_ff <= last_winner_in;
         was_idle_ff    <= was_idle_in;
         issue_cnt_ff   <= issue_cnt_in;
         proc_valid_ff  <= proc_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_idx_ff <= issue_idx_in;
      proc_idx_ff  <= proc_idx_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_idle_ff  <= rsp_idle_in;
   end

   edf_slot_mem #(
      .DEPTH (TASK_SLOTS),
      .WIDTH (WORD_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_data)
   );

   edf_pick_unit #(
      .COUNT_BITS (COUNT_BITS),
      .SLOT_BITS  (SLOT_BITS)
   ) u_pick_unit (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (pick_ctrl),
      .idx       (proc_idx_ff),
      .rd_word   (rd_data),
      .wb_word   (wb_word),
      .best_word (best_word),
      .best_idx  (best_idx),
      .found     (found)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_slot_ff};
   assign rsp_tuser  = rsp_idle_ff;

`ifndef ASSERT_OFF
   a_tick_blocks: assert property (@(posedge clock) disable iff (reset)
      (accept && is_tick) |=> !req_tready)
      else $error("tick did not start a selection");

   a_winner_ready: assert property (@(posedge clock) disable iff (reset)
      (commit && found) |-> ready_bits_ff[best_idx])
      else $error("elected slot is not ready");

   a_idle_flag: assert property (@(posedge clock) disable iff (reset)
      (commit && !found) |=> (was_idle_ff && rsp_valid_ff && rsp_idle_ff))
      else $error("idle result not recorded");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(commit))
      else $error("result loaded outside commit");
`endif

endmodule

@@ sim/edf_task_selector_tb.sv @@
// Self-checking testbench for the earliest-deadline task selector: directed table, then random episodes.
`timescale 1ns / 1ps

module edf_task_selector_tb;

   localparam int SLOTS = edf_pkg::TASK_SLOTS_DEF;
   localparam int CW = edf_pkg::COUNT_BITS_DEF;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [1:0] RUN_SPARE = 2'd3;
   localparam int RANDOM_WORDS = 1250;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int DIR_ROWS = 25;

   typedef struct {
      logic [1:0]    kind;
      logic [2:0]    slot;
      logic [CW-1:0] period;
      logic [CW-1:0] budget;
      logic [1:0]    run_state;
   } task_cmd_type;

   typedef struct {
      logic [2:0] slot;
      logic       idle;
   } sched_pick_type;

   typedef struct {
      task_cmd_type   cmd;
      bit             fixed;
      sched_pick_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // slot[2:0], period[18:3], budget[34:19], run_state[36:35]
   logic [1:0]  req_tuser = '0;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // chosen_slot[2:0]
   logic        rsp_tuser;        // idle_chosen[0]

   // scheduler image
   logic [CW-1:0] task_period [SLOTS];
   logic [CW-1:0] task_budget [SLOTS];
   logic [CW-1:0] period_left [SLOTS];
   logic [CW-1:0] budget_left [SLOTS];
   logic [1:0]    slot_state [SLOTS];
   logic [2:0]    last_winner;
   logic          was_idle;
   bit [SLOTS-1:0] loaded_slots;

   sched_pick_type expected_picks[$];
   sched_pick_type oldest_pick;
   dir_row_type    dir_rows [DIR_ROWS];

   int mismatches = 0;
   int words_taken = 0;
   int words_counted = 0;
   int cycle_count = 0;
   int send_calm = 0;
   int recv_calm = 0;
   int rsp_stall = 0;
   bit hold_rsp = 1'b0;

   edf_task_selector DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("edf_task_selector_tb: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatches < 30)
         $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
      mismatches++;
   endtask

   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic sched_pick_type elect_slot();
      sched_pick_type pick;
      logic [31:0] best_left;
      logic [31:0] best_per;
      logic [2:0]  best;
      bit          found;
      bit          any_ready;
      int          first;
      int          s;
      pick = '{3'd0, 1'b1};
      any_ready = 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (slot_state[i] == edf_pkg::RUN_READY) any_ready = 1'b1;
      if (!any_ready) begin
         was_idle = 1'b1;
         return pick;
      end
      first = was_idle ? 0 : int'(last_winner);
      best_left = edf_pkg::IDLE_REF;
      best_per = edf_pkg::IDLE_REF;
      best = '0;
      found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         s = (first + i) % SLOTS;
         if (slot_state[s] == edf_pkg::RUN_EMPTY) continue;
         if (period_left[s] == '0) begin
            period_left[s] = task_period[s];
            budget_left[s] = task_budget[s];
         end
         if (slot_state[s] != edf_pkg::RUN_READY) continue;
         if (budget_left[s] != '0 &&
             (32'(period_left[s]) < best_left ||
              (32'(period_left[s]) == best_left && 32'(task_period[s]) < best_per))) begin
            best_left = 32'(period_left[s]);
            best_per = 32'(task_period[s]);
            best = 3'(s);
            found = 1'b1;
         end
         if (period_left[s] != '0) period_left[s] = period_left[s] - 1'b1;
      end
      if (found) begin
         budget_left[best] = budget_left[best] - 1'b1;
         last_winner = best;
         was_idle = 1'b0;
         pick = '{best, 1'b0};
      end else begin
         was_idle = 1'b1;
      end
      return pick;
   endfunction

   function automatic task_cmd_type make_cmd(input logic [1:0] kind);
      task_cmd_type c;
      c.kind = kind;
      c.slot = 3'($urandom_range(0, SLOTS - 1));
      c.period = CW'($urandom_range(0, 65535));
      c.budget = CW'($urandom_range(0, 65535));
      c.run_state = 2'($urandom_range(0, 3));
      if (kind == edf_pkg::KIND_LOAD && $urandom_range(0, 99) < 85) begin
         c.period = CW'($urandom_range(0, 12));
         c.budget = CW'($urandom_range(0, 6));
      end
      // never wake a slot whose period and budget were never written
      if (kind == edf_pkg::KIND_STATE && !loaded_slots[c.slot])
         c.run_state = $urandom_range(0, 1) ? RUN_SPARE : edf_pkg::RUN_EMPTY;
      return c;
   endfunction

   function automatic dir_row_type row(input logic [1:0] kind, input int slot, input int period,
                                       input int budget, input logic [1:0] run_state,
                                       input bit fixed, input int want_slot,
                                       input bit want_idle);
      dir_row_type r;
      r.cmd = '{kind, 3'(slot), CW'(period), CW'(budget), run_state};
      r.fixed = fixed;
      r.want = '{3'(want_slot), want_idle};
      return r;
   endfunction

   task automatic issue_word(input task_cmd_type c, input bit fixed,
                             input sched_pick_type want);
      int             gap;
      sched_pick_type pick;
      gap = pick_gap(send_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= c.kind;
      req_tdata <= {3'b000, c.run_state, c.budget, c.period, c.slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_taken++;
      if (!(c.kind == KIND_SPARE || (c.kind == edf_pkg::KIND_STATE && c.run_state == RUN_SPARE)))
         words_counted++;
      case (c.kind)
         edf_pkg::KIND_TICK: begin
            pick = elect_slot();
            expected_picks.push_back(fixed ? want : pick);
         end
         edf_pkg::KIND_LOAD: begin
            task_period[c.slot] = c.period;
            task_budget[c.slot] = c.budget;
            period_left[c.slot] = '0;
            budget_left[c.slot] = '0;
            slot_state[c.slot] = edf_pkg::RUN_READY;
            loaded_slots[c.slot] = 1'b1;
         end
         edf_pkg::KIND_STATE: begin
            if (c.run_state != RUN_SPARE) slot_state[c.slot] = c.run_state;
         end
         default: ;
      endcase
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = pick_gap(recv_calm);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_picks.size() == 0) begin
            report_mismatch("unexpected result word", rsp_tdata[2:0], -1);
         end else begin
            oldest_pick = expected_picks.pop_front();
            if (rsp_tdata[2:0] != oldest_pick.slot)
               report_mismatch("chosen_slot", rsp_tdata[2:0], oldest_pick.slot);
            if (rsp_tuser != oldest_pick.idle)
               report_mismatch("idle_chosen", rsp_tuser, oldest_pick.idle);
         end
      end
   end

   // hold the result side off long enough for the block to back up
   initial begin
      wait (words_taken >= 300);
      hold_rsp = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      task_cmd_type   c;
      sched_pick_type none;
      int             n;

      none = '{3'd0, 1'b0};
      for (int i = 0; i < SLOTS; i++) begin
         task_period[i] = '0;
         task_budget[i] = '0;
         period_left[i] = '0;
         budget_left[i] = '0;
         slot_state[i] = edf_pkg::RUN_EMPTY;
      end
      last_winner = '0;
      was_idle = 1'b1;
      loaded_slots = '0;

      dir_rows[0]  = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 1, 0, 1);
      dir_rows[1]  = row(KIND_SPARE,          7, 65535, 65535, RUN_SPARE,          0, 0, 0);
      dir_rows[2]  = row(edf_pkg::KIND_STATE, 5, 0,     0,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[3]  = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 1, 0, 1);
      dir_rows[4]  = row(edf_pkg::KIND_LOAD,  7, 65535, 65535, edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[5]  = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 1, 7, 0);
      dir_rows[6]  = row(edf_pkg::KIND_LOAD,  0, 0,     0,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[7]  = row(edf_pkg::KIND_TICK,  7, 65535, 65535, RUN_SPARE,          0, 0, 0);
      dir_rows[8]  = row(edf_pkg::KIND_STATE, 7, 0,     0,     edf_pkg::RUN_WAIT,  0, 0, 0);
      dir_rows[9]  = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 1, 0, 1);
      dir_rows[10] = row(edf_pkg::KIND_STATE, 7, 0,     0,     RUN_SPARE,          0, 0, 0);
      dir_rows[11] = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 1, 0, 1);
      dir_rows[12] = row(edf_pkg::KIND_LOAD,  3, 5,     2,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[13] = row(edf_pkg::KIND_LOAD,  4, 5,     2,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[14] = row(edf_pkg::KIND_LOAD,  6, 3,     1,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[15] = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[16] = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[17] = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[18] = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[19] = row(edf_pkg::KIND_STATE, 7, 0,     0,     edf_pkg::RUN_READY, 0, 0, 0);
      dir_rows[20] = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[21] = row(edf_pkg::KIND_STATE, 0, 0,     0,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[22] = row(edf_pkg::KIND_LOAD,  1, 1,     65535, edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[23] = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 0, 0, 0);
      dir_rows[24] = row(edf_pkg::KIND_TICK,  0, 0,     0,     edf_pkg::RUN_EMPTY, 0, 0, 0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_ROWS; i++)
         issue_word(dir_rows[i].cmd, dir_rows[i].fixed, dir_rows[i].want);

      while (words_counted < RANDOM_WORDS) begin
         if ($urandom_range(0, 9) == 0) begin
            for (int s = 0; s < SLOTS; s++) begin
               c = make_cmd(edf_pkg::KIND_STATE);
               c.slot = 3'(s);
               c.run_state = edf_pkg::RUN_EMPTY;
               issue_word(c, 1'b0, none);
            end
         end
         n = $urandom_range(1, SLOTS);
         for (int j = 0; j < n; j++)
            issue_word(make_cmd(edf_pkg::KIND_LOAD), 1'b0, none);
         n = $urandom_range(10, 40);
         for (int j = 0; j < n; j++) begin
            case ($urandom_range(0, 99)) inside
               [0:71]:  c = make_cmd(edf_pkg::KIND_TICK);
               [72:83]: c = make_cmd(edf_pkg::KIND_STATE);
               [84:91]: c = make_cmd(edf_pkg::KIND_LOAD);
               [92:95]: c = make_cmd(KIND_SPARE);
               default: begin
                  c = make_cmd(edf_pkg::KIND_STATE);
                  c.run_state = RUN_SPARE;
               end
            endcase
            issue_word(c, 1'b0, none);
         end
      end
      req_tvalid <= 1'b0;

      while (expected_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("edf_task_selector_tb: done, clean");
      else
         $display("edf_task_selector_tb: done, errors");
      $finish;
   end

endmodule
